// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and step tables of the MD5 block compression core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_WRDS = 16;
    localparam int CNT_W    = $clog2(NUM_WRDS);
    localparam int NUM_RND  = 64;
    localparam int RND_W    = $clog2(NUM_RND);
    localparam int ADDR_W   = 4;

    // register map, word index taken from paddr[3:2]
    localparam logic [1:0] REG_INIT_A = 2'd0;
    localparam logic [1:0] REG_INIT_B = 2'd1;
    localparam logic [1:0] REG_INIT_C = 2'd2;
    localparam logic [1:0] REG_INIT_D = 2'd3;

    // standard initial chaining value
    localparam logic [WORD_W-1:0] INIT_A_RST = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B_RST = 32'hefcdab89;
    localparam logic [WORD_W-1:0] INIT_C_RST = 32'h98badcfe;
    localparam logic [WORD_W-1:0] INIT_D_RST = 32'h10325476;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ROUND = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    // four 32-bit words of chaining or working state
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } t_abcd;

    // sine-derived additive constant of each step
    function automatic logic [WORD_W-1:0] md5_k(input logic [RND_W-1:0] i);
        logic [WORD_W-1:0] k;
        unique case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // left-rotate amount, from the phase and the step within a group of four
    function automatic logic [4:0] md5_rot(input logic [RND_W-1:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = '0;
        endcase
        return s;
    endfunction

    // message word index used by each step (all arithmetic mod 16)
    function automatic logic [CNT_W-1:0] md5_g(input logic [RND_W-1:0] i);
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] g;
        lo = i[CNT_W-1:0];
        unique case (i[5:4])
            2'd0: g = lo;
            2'd1: g = CNT_W'(lo * 4'd5 + 4'd1);
            2'd2: g = CNT_W'(lo * 4'd3 + 4'd5);
            2'd3: g = CNT_W'(lo * 4'd7);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/md5_if.sv =====
// ----------------------------------------------------------------------------
// md5_in_if / md5_out_if
// Valid/ready channels for message word beats and digest beats.
// ----------------------------------------------------------------------------
interface md5_in_if
    import md5_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] msg_word;
    logic              start_message;

    modport source (output valid, output msg_word, output start_message, input ready);
    modport sink   (input valid, input msg_word, input start_message, output ready);
endinterface

interface md5_out_if
    import md5_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_a;
    logic [WORD_W-1:0] digest_b;
    logic [WORD_W-1:0] digest_c;
    logic [WORD_W-1:0] digest_d;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, input ready);
    modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                    input digest_d, output ready);
endinterface

// ===== sv/md5_round.sv =====
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step: round function, four-way add, variable left rotate.
// ----------------------------------------------------------------------------
module md5_round
    import md5_pkg::*;
(
    input  t_abcd             i_state,
    input  logic [RND_W-1:0]  i_rnd,
    input  logic [WORD_W-1:0] i_word,
    output t_abcd             o_state
);

    logic [WORD_W-1:0]   f;
    logic [WORD_W-1:0]   t;
    logic [2*WORD_W-1:0] rot_wide;

    // round function by phase
    always_comb begin
        unique case (i_rnd[5:4])
            2'd0: f = (i_state.b & i_state.c) | (~i_state.b & i_state.d);
            2'd1: f = (i_state.b & i_state.d) | (i_state.c & ~i_state.d);
            2'd2: f = i_state.b ^ i_state.c ^ i_state.d;
            2'd3: f = i_state.c ^ (i_state.b | ~i_state.d);
            default: f = '0;
        endcase
    end

    assign t        = i_state.a + f + i_word + md5_k(i_rnd);
    // rotate: upper half of the doubled word after the shift
    assign rot_wide = {t, t} << md5_rot(i_rnd);

    // register shuffle
    assign o_state.a = i_state.d;
    assign o_state.d = i_state.c;
    assign o_state.c = i_state.b;
    assign o_state.b = i_state.b + rot_wide[2*WORD_W-1:WORD_W];

endmodule

// ===== sv/md5_block_compression.sv =====
// ----------------------------------------------------------------------------
// md5_block_compression
// MD5 compression core: gathers sixteen message words, runs the 64 steps on
// one shared step unit and folds the result into the chaining value.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------
//  in_ch   | in  | valid / ready    | msg_word[31:0], start_message
//  out_ch  | out | valid / ready    | digest_a..digest_d[31:0]
//  apb     | in  | psel / penable   | paddr[3:0], pwdata/prdata[31:0]
//
//  Words 1 to 15 of a block are taken one per cycle.
//  The sixteenth word starts the 64 steps on the shared step unit, followed by
//  the chaining add.
//  The block is not ready while the steps run, nor while a finished digest
//  waits behind an earlier one not yet taken.
//  Reset (i_rst_n low, synchronous) restores the standard initial value.
// ----------------------------------------------------------------------------
module md5_block_compression
    import md5_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    md5_in_if.sink            in_ch,
    md5_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

    t_state            r_state, n_state;
    t_abcd             r_init;
    t_abcd             r_chain;
    t_abcd             r_work;
    t_abcd             r_dig;
    t_abcd             step_out;
    logic              r_out_vld;
    logic [CNT_W-1:0]  r_cnt;
    logic [RND_W-1:0]  r_rnd;
    logic [WORD_W-1:0] r_store [NUM_WRDS];
    logic [CNT_W-1:0]  wr_idx;
    logic              in_beat;
    logic              cfg_wr;
    logic              fold;
    logic [1:0]        reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_INIT_A: prdata = r_init.a;
            REG_INIT_B: prdata = r_init.b;
            REG_INIT_C: prdata = r_init.c;
            REG_INIT_D: prdata = r_init.d;
            default:    prdata = '0;
        endcase
    end

    // init value registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '{a: INIT_A_RST, b: INIT_B_RST, c: INIT_C_RST, d: INIT_D_RST};
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_INIT_A: r_init.a <= pwdata;
                REG_INIT_B: r_init.b <= pwdata;
                REG_INIT_C: r_init.c <= pwdata;
                REG_INIT_D: r_init.d <= pwdata;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign in_beat     = in_ch.valid & in_ch.ready;
    assign wr_idx      = in_ch.start_message ? '0 : r_cnt;
    // fold the block in once the output slot is free
    assign fold        = (r_state == S_DONE) & (~r_out_vld | out_ch.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_beat && wr_idx == CNT_W'(NUM_WRDS - 1)) n_state = S_ROUND;
            S_ROUND: if (r_rnd == RND_W'(NUM_RND - 1)) n_state = S_DONE;
            S_DONE:  if (fold) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // word count and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rnd <= '0;
        end else begin
            if (in_beat) r_cnt <= wr_idx + 1'b1;
            if (r_state == S_ROUND) r_rnd <= r_rnd + 1'b1;
        end
    end

    // word store
    always_ff @(posedge i_clk) begin
        if (in_beat) r_store[wr_idx] <= in_ch.msg_word;
    end

    // shared step unit
    md5_round u_round (
        .i_state (r_work),
        .i_rnd   (r_rnd),
        .i_word  (r_store[md5_g(r_rnd)]),
        .o_state (step_out)
    );

    // working state
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_work <= r_chain;
        end else if (r_state == S_ROUND) begin
            r_work <= step_out;
        end
    end

    // chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '{a: INIT_A_RST, b: INIT_B_RST, c: INIT_C_RST, d: INIT_D_RST};
        end else if (in_beat && in_ch.start_message) begin
            r_chain <= r_init;
        end else if (fold) begin
            r_chain.a <= r_chain.a + r_work.a;
            r_chain.b <= r_chain.b + r_work.b;
            r_chain.c <= r_chain.c + r_work.c;
            r_chain.d <= r_chain.d + r_work.d;
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (fold) begin
            r_dig.a <= r_chain.a + r_work.a;
            r_dig.b <= r_chain.b + r_work.b;
            r_dig.c <= r_chain.c + r_work.c;
            r_dig.d <= r_chain.d + r_work.d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fold) begin
            r_out_vld <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign out_ch.valid    = r_out_vld;
    assign out_ch.digest_a = r_dig.a;
    assign out_ch.digest_b = r_dig.b;
    assign out_ch.digest_c = r_dig.c;
    assign out_ch.digest_d = r_dig.d;

endmodule

// ===== sv/md5_chk.sv =====
// ----------------------------------------------------------------------------
// md5_chk
// Port-level checks on the MD5 compression core, bound to the top level.
// ----------------------------------------------------------------------------
module md5_chk
    import md5_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_start,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [WORD_W-1:0] i_digest_a
);

    // held digest beat stays valid, with digest_a unchanged, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_digest_a))
        else $error("digest beat dropped or changed while stalled");

    // reset leaves the core empty and ready
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("core not idle after reset");

    // a start word is word 0 and never completes a block
    a_start_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_start |=> i_in_ready)
        else $error("compression started on a start word");

    // a new digest only follows a compression run
    a_dig_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("digest appeared without a compression run");

endmodule

bind md5_block_compression md5_chk u_md5_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_in_start  (in_ch.start_message),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_digest_a  (out_ch.digest_a)
);

// ===== tb/md5_block_compression_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_block_compression_tb
// Self-checking bench for the MD5 compression core. Message word beats go in
// under random gaps and digest beats come out under random back-pressure. A
// local MD5 step model predicts each digest and checks it field by field.
// The initial-value registers are reprogrammed over the APB port between
// traffic phases and read back.
// ----------------------------------------------------------------------------
module md5_block_compression_tb;
    import md5_pkg::*;

    localparam int GAP_PCT     = 21;     // idle chance per cycle, both sides
    localparam int SETTLE_CYC  = 100;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    md5_in_if  in_ch ();
    md5_out_if out_ch ();

    md5_block_compression u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // per-step additive constants, floor(abs(sin(i + 1)) * 2^32)
    logic [31:0] sine_tab [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts: four per round group
    logic [4:0] shift_tab [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // predictor state
    logic [31:0] init_regs [4];
    logic [31:0] chain [4];
    logic [31:0] word_buf [16];
    logic [3:0]  fill;
    t_abcd       digest_due_q [$];

    int err_cnt   = 0;
    int cycle_cnt = 0;
    bit calm      = 1'b0;    // set: no idling on either side

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("md5_block_compression_tb: errors");
            $finish;
        end
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // 64 steps over the gathered block, folded into the chaining value
    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int          g, i, grp;
        t_abcd       res;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (i = 0; i < 64; i++) begin
            grp = i / 16;
            unique case (grp)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = a + f + word_buf[g[3:0]] + sine_tab[i[5:0]];
            a = d;
            d = c;
            c = b;
            b = b + rotl(t, shift_tab[4'(grp * 4 + i % 4)]);
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        res.a = chain[0];
        res.b = chain[1];
        res.c = chain[2];
        res.d = chain[3];
        digest_due_q = {digest_due_q, res};
    endtask

    // prediction for one accepted word beat
    task automatic take_word(input logic [31:0] w, input logic st);
        if (st) begin
            chain = init_regs;    // a partly gathered block is dropped
            fill  = '0;
        end
        word_buf[fill] = w;
        fill = fill + 4'd1;
        if (fill == 4'd0) begin
            md5_compress();
        end
    endtask

    // one word beat, with a random gap ahead of it
    task automatic send_word(input logic [31:0] w, input logic st);
        while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.msg_word      <= w;
        in_ch.start_message <= st;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        take_word(w, st);
    endtask

    // word content, biased towards the extremes
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 32'h00000000;
        if (r < 16)
            return 32'hffffffff;
        return $urandom();
    endfunction

    // stop sending and let every expected digest arrive
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (digest_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        init_regs[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // APB read, compared with the last value written
    task automatic check_reg(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== init_regs[idx]) begin
            $error("prdata[%0d]: expected %h, got %h", idx, init_regs[idx], prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // New initial value, written with six words of a block pending. The pending
    // block is then finished without a start flag, so it must still use the old
    // chaining value.
    task automatic change_init(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d);
        int k;
        for (k = 0; k < 6; k++) send_word(pick_word(), k == 0);
        wait_idle();
        write_reg(REG_INIT_A, a);
        write_reg(REG_INIT_B, b);
        write_reg(REG_INIT_C, c);
        write_reg(REG_INIT_D, d);
        check_reg(REG_INIT_A);
        check_reg(REG_INIT_B);
        check_reg(REG_INIT_C);
        check_reg(REG_INIT_D);
        for (k = 0; k < 10; k++) send_word(pick_word(), 1'b0);
    endtask

    // mostly whole messages; some continuations, abandoned blocks and noise
    task automatic run_traffic(input int n_items);
        int   sent, r, len, k;
        logic st;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                len = 16 * $urandom_range(1, 3);
            else if (r < 85)
                len = 16;
            else if (r < 94)
                len = $urandom_range(1, 15);
            else
                len = $urandom_range(1, 20);
            for (k = 0; k < len; k++) begin
                if (r >= 94)
                    st = ($urandom_range(0, 7) == 0);
                else
                    st = (k == 0) && !(r >= 72 && r < 85);
                send_word(pick_word(), st);
            end
            sent += len;
        end
    endtask

    // reset values; a partial message dropped by a restart; extreme words
    task automatic test_first_block_after_reset();
        logic [31:0] blk [16];
        int          k;
        blk = '{32'h00000080, 32'hffffffff, 32'h00000000, 32'haaaaaaaa,
                32'h55555555, 32'h80000000, 32'h00000001, 32'hffffffff,
                32'h00000000, 32'h7fffffff, 32'hfffffffe, 32'h00000000,
                32'h0f0f0f0f, 32'hf0f0f0f0, 32'h00000000, 32'hffffffff};
        send_word(32'hffffffff, 1'b1);
        send_word(32'h00000000, 1'b0);
        send_word(32'h80000000, 1'b0);
        send_word(32'h00000001, 1'b0);
        for (k = 0; k < 16; k++) send_word(blk[k], k == 0);
        wait_idle();
    endtask

    task automatic test_init_extremes();
        change_init(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
        run_traffic(290);
        change_init(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        run_traffic(290);
    endtask

    task automatic test_init_random();
        change_init($urandom(), $urandom(), $urandom(), $urandom());
        run_traffic(290);
        change_init(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0);
        run_traffic(290);
    endtask

    // standard initial value back, full rate on both sides
    task automatic test_unstalled_stream();
        calm = 1'b1;
        change_init(32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476);
        run_traffic(310);
        wait_idle();
        calm = 1'b0;
    endtask

    // digest beats: compare with the oldest prediction, then pick next ready
    always @(posedge i_clk) begin : digest_mon
        t_abcd want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_due_q.size() == 0) begin
                $error("unexpected digest beat: %h %h %h %h", out_ch.digest_a,
                       out_ch.digest_b, out_ch.digest_c, out_ch.digest_d);
                err_cnt++;
            end else begin
                want = digest_due_q.pop_front();
                if (out_ch.digest_a !== want.a) begin
                    $error("digest_a: expected %h, got %h", want.a, out_ch.digest_a);
                    err_cnt++;
                end
                if (out_ch.digest_b !== want.b) begin
                    $error("digest_b: expected %h, got %h", want.b, out_ch.digest_b);
                    err_cnt++;
                end
                if (out_ch.digest_c !== want.c) begin
                    $error("digest_c: expected %h, got %h", want.c, out_ch.digest_c);
                    err_cnt++;
                end
                if (out_ch.digest_d !== want.d) begin
                    $error("digest_d: expected %h, got %h", want.d, out_ch.digest_d);
                    err_cnt++;
                end
            end
        end
        out_ch.ready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
    end

    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.msg_word      <= '0;
        in_ch.start_message <= 1'b0;
        init_regs = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        chain     = init_regs;
        fill      = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_block_after_reset();
        test_init_extremes();
        test_init_random();
        test_unstalled_stream();

        wait_idle();
        if (err_cnt == 0)
            $display("md5_block_compression_tb: clean");
        else
            $display("md5_block_compression_tb: errors");
        $finish;
    end

endmodule
